// ===== sv/kset_pkg.sv =====
package kset_pkg;

  localparam int unsigned KeysDefault = 64;
  localparam int unsigned KeyW        = 6;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_RELEASED      = 2'd0,
    ST_JUST_PRESSED  = 2'd1,
    ST_PRESSED       = 2'd2,
    ST_JUST_RELEASED = 2'd3
  } key_state_t;

  typedef enum logic [1:0] {
    ACT_RELEASE = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_REPEAT  = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  localparam logic RK_EVENT = 1'b0;
  localparam logic RK_QUERY = 1'b1;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SWEEP,
    CS_FLUSH,
    CS_FINISH,
    CS_QUERY
  } ctrl_state_t;

  typedef struct packed {
    logic report_wr;
    logic query_rd;
    logic sweep_init;
    logic sweep_rd;
    logic finish;
    logic query_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } dp_status_t;

  function automatic key_state_t next_key_state(key_state_t st, action_t p);
    key_state_t nw;
    unique case (st)
      ST_RELEASED:      nw = (p == ACT_PRESS) ? ST_JUST_PRESSED : ST_RELEASED;
      ST_JUST_PRESSED:  nw = (p == ACT_PRESS || p == ACT_NONE) ? ST_PRESSED
                                                               : ST_JUST_PRESSED;
      ST_PRESSED:       nw = (p == ACT_RELEASE) ? ST_JUST_RELEASED : ST_PRESSED;
      default:          nw = (p == ACT_RELEASE || p == ACT_NONE) ? ST_RELEASED
                                                                 : ST_JUST_RELEASED;
    endcase
    return nw;
  endfunction

endpackage

// ===== sv/key_state_edge_tracker_top.sv =====
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+--------------------------------
// input    | kind, key_index, action                 | taken when start && !busy
// result   | result_kind, result_key, key_state, last| one cycle each, on result_valid
//
// A report leaves busy low. A query holds busy for one cycle; its answer is on the
// result ports in the cycle after that, when busy is low again. A tick holds busy in
// the sweep, flush and finish states: the sweep reads one key a cycle from the state
// and pending stores; each event waits for the next changed key or the end of the
// sweep, so the final one, with last set, comes in the first cycle after busy drops.
// Reset is synchronous and clears every key to released with no pending action.
// The receiver cannot stall; results are never held.
module key_state_edge_tracker_top #(
  parameter int unsigned KEYS = kset_pkg::KeysDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                kind,
  input  logic [kset_pkg::KeyW-1:0] key_index,
  input  logic [1:0]                action,
  output logic                      result_valid,
  output logic                      result_kind,
  output logic [kset_pkg::KeyW-1:0] result_key,
  output logic [1:0]                key_state,
  output logic                      last
);

  kset_pkg::ctl_cmd_t   cmd;
  kset_pkg::dp_status_t status;

  kset_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  kset_datapath #(
    .KEYS (KEYS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .key_index    (key_index),
    .action       (action),
    .status       (status),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .result_key   (result_key),
    .key_state    (key_state),
    .last         (last)
  );

endmodule

// ===== sv/kset_ctrl.sv =====
module kset_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            kind,
  input  kset_pkg::dp_status_t  status,
  output kset_pkg::ctl_cmd_t    cmd,
  output logic                  busy
);

  kset_pkg::ctrl_state_t state, state_next;
  logic                  accept;

  assign accept = start && (state == kset_pkg::CS_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kset_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kset_pkg::CS_IDLE: begin
        if (accept && kind == kset_pkg::KIND_TICK) begin
          state_next = kset_pkg::CS_SWEEP;
        end else if (accept && kind == kset_pkg::KIND_QUERY) begin
          state_next = kset_pkg::CS_QUERY;
        end
      end
      kset_pkg::CS_SWEEP: begin
        if (status.sweep_last) begin
          state_next = kset_pkg::CS_FLUSH;
        end
      end
      kset_pkg::CS_FLUSH:  state_next = kset_pkg::CS_FINISH;
      kset_pkg::CS_FINISH: state_next = kset_pkg::CS_IDLE;
      kset_pkg::CS_QUERY:  state_next = kset_pkg::CS_IDLE;
      default:             state_next = kset_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      kset_pkg::CS_IDLE: begin
        busy           = 1'b0;
        cmd.report_wr  = accept && kind == kset_pkg::KIND_REPORT;
        cmd.query_rd   = accept && kind == kset_pkg::KIND_QUERY;
        cmd.sweep_init = accept && kind == kset_pkg::KIND_TICK;
      end
      kset_pkg::CS_SWEEP:  cmd.sweep_rd  = 1'b1;
      kset_pkg::CS_FLUSH:  cmd           = '0;
      kset_pkg::CS_FINISH: cmd.finish    = 1'b1;
      kset_pkg::CS_QUERY:  cmd.query_out = 1'b1;
      default:             cmd           = '0;
    endcase
  end

endmodule

// ===== sv/kset_datapath.sv =====
module kset_datapath #(
  parameter int unsigned KEYS = kset_pkg::KeysDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  kset_pkg::ctl_cmd_t          cmd,
  input  logic [kset_pkg::KeyW-1:0]   key_index,
  input  logic [1:0]                  action,
  output kset_pkg::dp_status_t        status,
  output logic                        result_valid,
  output logic                        result_kind,
  output logic [kset_pkg::KeyW-1:0]   result_key,
  output logic [1:0]                  key_state,
  output logic                        last
);

  localparam int unsigned AW = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam logic [AW-1:0] LastKey = AW'(KEYS - 1);

  // Key state and pending action stores; an entry whose valid bit is clear
  // reads as released / none.
  logic [1:0]      state_mem [KEYS];
  logic [1:0]      pend_mem  [KEYS];
  logic [KEYS-1:0] state_vld;
  logic [KEYS-1:0] pend_vld;

  logic            key_in_range;
  logic [AW-1:0]   in_addr;
  logic [AW-1:0]   cnt;
  logic [AW-1:0]   rd_addr;

  logic [1:0]      st_rd;
  logic            st_rd_vld;
  logic [1:0]      pend_rd;
  logic            pend_rd_vld;

  logic            s1_valid;
  logic [AW-1:0]   s1_key;

  logic            q_in_range;
  logic [kset_pkg::KeyW-1:0] q_key;

  logic            hold_valid;
  logic [AW-1:0]   hold_key;
  logic [1:0]      hold_state;

  kset_pkg::key_state_t old_st, new_st;
  kset_pkg::action_t    pend_act;
  logic                 changed;

  assign key_in_range = ({1'b0, key_index} < (kset_pkg::KeyW + 1)'(KEYS));
  assign in_addr      = key_index[AW-1:0];
  assign rd_addr      = cmd.query_rd ? in_addr : cnt;
  assign status.sweep_last = (cnt == LastKey);

  assign old_st   = st_rd_vld ? kset_pkg::key_state_t'(st_rd) : kset_pkg::ST_RELEASED;
  assign pend_act = pend_rd_vld ? kset_pkg::action_t'(pend_rd) : kset_pkg::ACT_NONE;
  assign new_st   = kset_pkg::next_key_state(old_st, pend_act);
  assign changed  = (new_st != old_st);

  // Memory ports
  always_ff @(posedge clk) begin
    st_rd   <= state_mem[rd_addr];
    pend_rd <= pend_mem[cnt];
    if (cmd.report_wr && key_in_range) begin
      pend_mem[in_addr] <= action;
    end
    if (s1_valid) begin
      state_mem[s1_key] <= new_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_vld   <= '0;
      pend_vld    <= '0;
      st_rd_vld   <= 1'b0;
      pend_rd_vld <= 1'b0;
    end else begin
      st_rd_vld   <= state_vld[rd_addr];
      pend_rd_vld <= pend_vld[cnt];
      if (cmd.report_wr && key_in_range) begin
        pend_vld[in_addr] <= 1'b1;
      end
      // Drop the pending action once the sweep has read it
      if (cmd.sweep_rd) begin
        pend_vld[cnt] <= 1'b0;
      end
      if (s1_valid) begin
        state_vld[s1_key] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.sweep_rd;
      if (cmd.sweep_init) begin
        cnt <= '0;
      end else if (cmd.sweep_rd && !status.sweep_last) begin
        cnt <= cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_key <= cnt;
    if (cmd.query_rd) begin
      q_key      <= key_index;
      q_in_range <= key_in_range;
    end
  end

  // One event is held back so the final one of a sweep can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.sweep_init) begin
        hold_valid <= 1'b0;
      end else if (s1_valid && changed) begin
        hold_valid   <= 1'b1;
        result_valid <= hold_valid;
      end else if (cmd.finish) begin
        hold_valid   <= 1'b0;
        result_valid <= hold_valid;
      end else if (cmd.query_out) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && changed) begin
      hold_key   <= s1_key;
      hold_state <= new_st;
    end
    if ((s1_valid && changed) || cmd.finish) begin
      result_kind <= kset_pkg::RK_EVENT;
      result_key  <= kset_pkg::KeyW'(hold_key);
      key_state   <= hold_state;
      last        <= cmd.finish;
    end else if (cmd.query_out) begin
      result_kind <= kset_pkg::RK_QUERY;
      result_key  <= q_key;
      key_state   <= (q_in_range && st_rd_vld) ? st_rd : kset_pkg::ST_RELEASED;
      last        <= 1'b1;
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 27;

  typedef struct {
    logic       rk;
    logic [5:0] key;
    logic [1:0] st;
    logic       last;
  } key_result_t;

  class key_event_scoreboard;
    kset_pkg::key_state_t key_states[kset_pkg::KeysDefault];
    kset_pkg::action_t    pending_actions[kset_pkg::KeysDefault];
    key_result_t          expected_results[$];
    int unsigned          mismatches;

    function new();
      foreach (key_states[i]) begin
        key_states[i] = kset_pkg::ST_RELEASED;
        pending_actions[i] = kset_pkg::ACT_NONE;
      end
      mismatches = 0;
    endfunction

    function kset_pkg::key_state_t advance_key(kset_pkg::key_state_t st,
                                               kset_pkg::action_t p);
      case (st)
        kset_pkg::ST_RELEASED: begin
          if (p == kset_pkg::ACT_PRESS) return kset_pkg::ST_JUST_PRESSED;
        end
        kset_pkg::ST_JUST_PRESSED: begin
          if (p == kset_pkg::ACT_PRESS || p == kset_pkg::ACT_NONE)
            return kset_pkg::ST_PRESSED;
        end
        kset_pkg::ST_PRESSED: begin
          if (p == kset_pkg::ACT_RELEASE) return kset_pkg::ST_JUST_RELEASED;
        end
        default: begin
          if (p == kset_pkg::ACT_RELEASE || p == kset_pkg::ACT_NONE)
            return kset_pkg::ST_RELEASED;
        end
      endcase
      return st;
    endfunction

    // Work out the results of one accepted item and queue them.
    function void note_item(logic [1:0] k, logic [5:0] idx, logic [1:0] act);
      key_result_t          r;
      kset_pkg::key_state_t nw;
      int                   first_new;
      first_new = expected_results.size();
      case (k)
        kset_pkg::KIND_REPORT: begin
          if (idx < kset_pkg::KeysDefault)
            pending_actions[idx] = kset_pkg::action_t'(act);
        end
        kset_pkg::KIND_TICK: begin
          for (int i = 0; i < kset_pkg::KeysDefault; i++) begin
            nw = advance_key(key_states[i], pending_actions[i]);
            pending_actions[i] = kset_pkg::ACT_NONE;
            if (nw != key_states[i]) begin
              r.rk = kset_pkg::RK_EVENT;
              r.key = 6'(i);
              r.st = nw;
              r.last = 1'b0;
              expected_results = {expected_results, r};
            end
            key_states[i] = nw;
          end
          if (expected_results.size() > first_new)
            expected_results[expected_results.size() - 1].last = 1'b1;
        end
        kset_pkg::KIND_QUERY: begin
          r.rk = kset_pkg::RK_QUERY;
          r.key = idx;
          r.st = (idx < kset_pkg::KeysDefault) ? key_states[idx] : kset_pkg::ST_RELEASED;
          r.last = 1'b1;
          expected_results = {expected_results, r};
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic rk, logic [5:0] key, logic [1:0] st, logic last);
      key_result_t e;
      string       exp_s;
      string       got_s;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d key=%0d state=%0d last=%0d",
                   rk, key, st, last);
        return;
      end
      e = expected_results.pop_front();
      if (rk !== e.rk || key !== e.key || st !== e.st || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          exp_s = $sformatf("kind=%0d key=%0d state=%0d last=%0d",
                            e.rk, e.key, e.st, e.last);
          got_s = $sformatf("kind=%0d key=%0d state=%0d last=%0d", rk, key, st, last);
          $display("result mismatch: expected %s, got %s", exp_s, got_s);
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] kind = 2'd0;
  logic [5:0] key_index = 6'd0;
  logic [1:0] action = 2'd0;
  logic       busy;
  logic       result_valid;
  logic       result_kind;
  logic [5:0] result_key;
  logic [1:0] key_state;
  logic       last;

  key_event_scoreboard sb = new();
  int unsigned idle_pct = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  key_state_edge_tracker_top DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .key_index(key_index),
    .action(action),
    .result_valid(result_valid),
    .result_kind(result_kind),
    .result_key(result_key),
    .key_state(key_state),
    .last(last)
  );

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result_kind, result_key, key_state, last);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("key_state_edge_tracker_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the item until it is taken, then maybe drop start for a while.
  task automatic send_item(input logic [1:0] k, input logic [5:0] idx, input logic [1:0] act);
    start <= 1'b1;
    kind <= k;
    key_index <= idx;
    action <= act;
    do @(posedge clk); while (busy);
    sb.note_item(k, idx, act);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      if ($urandom_range(9) == 0) repeat ($urandom_range(10, 70)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    send_item(kset_pkg::KIND_QUERY, 6'd0, kset_pkg::ACT_RELEASE);
    send_item(kset_pkg::KIND_QUERY, 6'd63, kset_pkg::ACT_NONE);
    send_item(kset_pkg::KIND_REPORT, 6'd0, kset_pkg::ACT_PRESS);
    send_item(kset_pkg::KIND_REPORT, 6'd63, kset_pkg::ACT_PRESS);
    send_item(kset_pkg::KIND_REPORT, 6'd5, kset_pkg::ACT_REPEAT);
    send_item(kset_pkg::KIND_REPORT, 6'd7, kset_pkg::ACT_RELEASE);
    send_item(kset_pkg::KIND_REPORT, 6'd9, kset_pkg::ACT_NONE);
    send_item(kset_pkg::KIND_NONE, 6'd63, kset_pkg::ACT_NONE);
    // fields that a tick does not use are ignored
    send_item(kset_pkg::KIND_TICK, 6'd63, kset_pkg::ACT_NONE);
    send_item(kset_pkg::KIND_QUERY, 6'd0, kset_pkg::ACT_PRESS);
    send_item(kset_pkg::KIND_REPORT, 6'd0, kset_pkg::ACT_REPEAT);
    send_item(kset_pkg::KIND_TICK, 6'd0, kset_pkg::ACT_RELEASE);
    send_item(kset_pkg::KIND_TICK, 6'd21, kset_pkg::ACT_REPEAT);
    // nothing changes here, so no event at all
    send_item(kset_pkg::KIND_TICK, 6'd42, kset_pkg::ACT_PRESS);
    send_item(kset_pkg::KIND_REPORT, 6'd0, kset_pkg::ACT_RELEASE);
    send_item(kset_pkg::KIND_REPORT, 6'd63, kset_pkg::ACT_RELEASE);
    send_item(kset_pkg::KIND_TICK, 6'd0, kset_pkg::ACT_RELEASE);
    send_item(kset_pkg::KIND_REPORT, 6'd0, kset_pkg::ACT_PRESS);
    send_item(kset_pkg::KIND_QUERY, 6'd63, kset_pkg::ACT_REPEAT);
    send_item(kset_pkg::KIND_TICK, 6'd0, kset_pkg::ACT_RELEASE);
    send_item(kset_pkg::KIND_TICK, 6'd0, kset_pkg::ACT_RELEASE);
    send_item(kset_pkg::KIND_QUERY, 6'd0, kset_pkg::ACT_RELEASE);
    send_item(kset_pkg::KIND_QUERY, 6'd63, kset_pkg::ACT_RELEASE);
  endtask

  initial begin
    int unsigned phase_idle[4] = '{0, 57, 0, 11};
    int unsigned r;
    logic [5:0]  idx;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        // keep most traffic on a few keys so they walk through every state
        idx = $urandom_range(1) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
        if (r < 50)
          send_item(kset_pkg::KIND_REPORT, idx, 2'($urandom_range(3)));
        else if (r < 68)
          send_item(kset_pkg::KIND_TICK, 6'($urandom_range(63)), 2'($urandom_range(3)));
        else if (r < 95)
          send_item(kset_pkg::KIND_QUERY, idx, 2'($urandom_range(3)));
        else
          send_item(kset_pkg::KIND_NONE, idx, 2'($urandom_range(3)));
      end
    end
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (kset_pkg::KeysDefault + 8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("key_state_edge_tracker_top verification clean");
    end else begin
      $display("key_state_edge_tracker_top verification failed");
    end
    $finish;
  end

endmodule
